/* rtl/btmx_pkg.sv */
package btmx_pkg;

  localparam int WIDTH  = 32;
  localparam int NODES  = 32768;
  localparam int DATA_W = 32;
  localparam int NODE_W = $clog2(NODES);
  localparam int CNT_W  = $clog2(NODES + 1);
  localparam int LVL_W  = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  // walk token handed from one level cell to the next
  typedef struct packed {
    logic              valid;
    logic              insert;
    logic              alive;
    logic              fresh;
    logic [NODE_W-1:0] node;
    logic [WIDTH-1:0]  key;
    logic [WIDTH-1:0]  best;
  } link_t;

endpackage

/* rtl/btmx_cell.sv */
module btmx_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [btmx_pkg::LVL_W-1:0]  level_i,
  input  btmx_pkg::link_t             link_i,
  input  logic [btmx_pkg::NODE_W-1:0] free_node_i,
  output logic                        alloc_o,
  output btmx_pkg::link_t             link_o
);

  localparam int NW = btmx_pkg::NODE_W;

  // children of every node that sits at this cell's depth: {one, zero}
  logic [2*NW-1:0] mem [btmx_pkg::NODES];

  logic            valid_q;
  btmx_pkg::link_t req_q;
  logic [2*NW-1:0] rdata_q;

  logic [btmx_pkg::LVL_W-1:0] bit_pos;
  logic                       key_bit;
  logic [2*NW-1:0]            entry;
  logic [NW-1:0]              child_same;
  logic [NW-1:0]              child_other;
  logic                       wr_en;
  logic [2*NW-1:0]            wr_data;
  btmx_pkg::link_t            link_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= link_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_i.valid) begin
      req_q   <= link_i;
      rdata_q <= mem[link_i.node];
    end
    if (wr_en) begin
      mem[req_q.node] <= wr_data;
    end
  end

  always_comb begin
    bit_pos = btmx_pkg::LVL_W'(btmx_pkg::WIDTH - 1) - level_i;
    key_bit = req_q.key[bit_pos];
    // a node allocated one level up has no stored children yet
    entry       = req_q.fresh ? '0 : rdata_q;
    child_same  = key_bit ? entry[2*NW-1:NW] : entry[NW-1:0];
    child_other = key_bit ? entry[NW-1:0] : entry[2*NW-1:NW];

    wr_en   = valid_q && req_q.insert && (child_same == '0);
    wr_data = entry;
    if (key_bit) begin
      wr_data[2*NW-1:NW] = free_node_i;
    end else begin
      wr_data[NW-1:0] = free_node_i;
    end

    link_d       = req_q;
    link_d.valid = valid_q;
    link_d.fresh = 1'b0;
    if (req_q.insert) begin
      if (child_same == '0) begin
        link_d.node  = free_node_i;
        link_d.fresh = 1'b1;
      end else begin
        link_d.node = child_same;
      end
    end else if (req_q.alive) begin
      if (child_other != '0) begin
        link_d.best[bit_pos] = 1'b1;
        link_d.node          = child_other;
      end else begin
        link_d.node  = child_same;
        link_d.alive = (child_same != '0);
      end
    end
  end

  assign alloc_o = wr_en;
  assign link_o  = link_d;

endmodule

/* rtl/binary_trie_max_xor.sv */
// maximum-xor trie: keeps a set of 32-bit values and answers max(key ^ stored)
// input channel s_axis: tuser carries the command (insert, query, clear),
//   tdata the value to insert or the key of a query
// output channel m_axis: one result per request; tdata is the maximum xor of a
//   query (0 otherwise), tuser flags an empty set or a rejected insert
// the trie is a row of 32 level cells, one per bit; each cell owns the child
//   pointers of the nodes at its depth and passes the walk token on each cycle
// insert and query: the result is registered once the walk token has passed
//   the launch register and all 32 cells in turn, at one node read per cell
// clear, unused command, empty query and rejected insert: result next cycle
// one request at a time; a new request is taken once the result is taken,
//   so no request is accepted while an insert or query walk is in flight
// an insert is rejected whole when fewer than 32 free nodes remain
// reset empties the trie at once (no clearing pass); while m_axis_tready is
//   low the result holds and no request is accepted
module binary_trie_max_xor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [btmx_pkg::DATA_W-1:0] s_axis_tdata,  // value
  input  logic [1:0]                  s_axis_tuser,  // cmd
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [btmx_pkg::DATA_W-1:0] m_axis_tdata,  // max_xor
  output logic [1:0]                  m_axis_tuser   // set_empty, store_full
);

  localparam int W = btmx_pkg::WIDTH;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  state_e                       state_q, state_d;
  logic [btmx_pkg::CNT_W-1:0]   next_free_q, next_free_d;
  logic                         has_values_q, has_values_d;
  logic                         launch_vld_q, launch_vld_d;
  btmx_pkg::link_t              launch_q, launch_d;
  logic [btmx_pkg::DATA_W-1:0]  res_max_q, res_max_d;
  logic                         res_empty_q, res_empty_d;
  logic                         res_full_q, res_full_d;

  btmx_pkg::link_t              launch_link;
  btmx_pkg::link_t              links [W+1];
  logic [W-1:0]                 alloc;
  logic                         accept;
  logic                         no_room;
  btmx_pkg::cmd_e               cmd;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign cmd     = btmx_pkg::cmd_e'(s_axis_tuser);
  assign no_room = ({1'b0, next_free_q} + (btmx_pkg::CNT_W + 1)'(W))
                   > (btmx_pkg::CNT_W + 1)'(btmx_pkg::NODES);

  always_comb begin
    launch_link       = launch_q;
    launch_link.valid = launch_vld_q;
  end
  assign links[0] = launch_link;

  for (genvar d = 0; d < W; d++) begin : g_cell
    btmx_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .level_i    (btmx_pkg::LVL_W'(d)),
      .link_i     (links[d]),
      .free_node_i(next_free_q[btmx_pkg::NODE_W-1:0]),
      .alloc_o    (alloc[d]),
      .link_o     (links[d+1])
    );
  end

  always_comb begin
    state_d      = state_q;
    next_free_d  = next_free_q;
    has_values_d = has_values_q;
    launch_vld_d = 1'b0;
    launch_d     = launch_q;
    res_max_d    = res_max_q;
    res_empty_d  = res_empty_q;
    res_full_d   = res_full_q;

    if (|alloc) begin
      next_free_d = next_free_q + btmx_pkg::CNT_W'(1);
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_max_d       = '0;
          res_empty_d     = 1'b0;
          res_full_d      = 1'b0;
          launch_d.valid  = 1'b1;
          launch_d.insert = (cmd == btmx_pkg::CMD_INSERT);
          launch_d.alive  = 1'b1;
          launch_d.fresh  = !has_values_q;
          launch_d.node   = '0;
          launch_d.key    = W'(s_axis_tdata);
          launch_d.best   = '0;
          state_d         = ST_OUT;
          case (cmd)
            btmx_pkg::CMD_INSERT: begin
              if (no_room) begin
                res_full_d = 1'b1;
              end else begin
                launch_vld_d = 1'b1;
                state_d      = ST_WALK;
              end
            end
            btmx_pkg::CMD_QUERY: begin
              if (!has_values_q) begin
                res_empty_d = 1'b1;
              end else begin
                launch_vld_d = 1'b1;
                state_d      = ST_WALK;
              end
            end
            btmx_pkg::CMD_CLEAR: begin
              next_free_d  = btmx_pkg::CNT_W'(1);
              has_values_d = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        if (links[W].valid) begin
          if (links[W].insert) begin
            has_values_d = 1'b1;
          end else begin
            res_max_d = btmx_pkg::DATA_W'(links[W].best);
          end
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      next_free_q  <= btmx_pkg::CNT_W'(1);
      has_values_q <= 1'b0;
      launch_vld_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      next_free_q  <= next_free_d;
      has_values_q <= has_values_d;
      launch_vld_q <= launch_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    launch_q    <= launch_d;
    res_max_q   <= res_max_d;
    res_empty_q <= res_empty_d;
    res_full_q  <= res_full_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = res_max_q;
  assign m_axis_tuser  = {res_full_q, res_empty_q};

`ifndef NO_ASSERTIONS
  a_one_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(alloc))
    else $error("more than one level allocated a node in one cycle");

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_free_q <= btmx_pkg::CNT_W'(btmx_pkg::NODES))
    else $error("node allocator ran past the store");

  a_token_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    links[W].valid |-> state_q == ST_WALK)
    else $error("walk token left the last cell outside a walk");

  a_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    launch_vld_q |-> $past(accept))
    else $error("walk launched without an accepted request");
`endif

endmodule

/* tb/tb_binary_trie_max_xor.sv */
`timescale 1ns / 100ps

module tb_binary_trie_max_xor;
  import btmx_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] max_xor;
    logic              set_empty;
    logic              store_full;
  } trie_result_t;

  class trie_scoreboard;
    int unsigned  kids[NODES][2];
    int unsigned  free_idx;
    bit           has_values;
    trie_result_t expected_q[$];
    int           errors;
    int           seen;

    function new();
      errors = 0;
      seen   = 0;
      wipe();
    endfunction

    function void wipe();
      kids[0][0] = 0;
      kids[0][1] = 0;
      free_idx   = 1;
      has_values = 1'b0;
    endfunction

    // true once the next insert would be turned away
    function bit near_full();
      return free_idx + WIDTH > NODES;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit insert_key(logic [WIDTH-1:0] v);
      int unsigned node;
      int unsigned nxt;
      if (near_full()) return 1'b0;
      node = 0;
      for (int i = WIDTH - 1; i >= 0; i--) begin
        nxt = kids[node][v[i]];
        if (nxt == 0) begin
          nxt = free_idx;
          free_idx++;
          kids[nxt][0] = 0;
          kids[nxt][1] = 0;
          kids[node][v[i]] = nxt;
        end
        node = nxt;
      end
      has_values = 1'b1;
      return 1'b1;
    endfunction

    // greedy walk: take the branch opposite the key bit wherever it exists
    function logic [WIDTH-1:0] max_xor_of(logic [WIDTH-1:0] key);
      int unsigned      node;
      int unsigned      alt;
      logic [WIDTH-1:0] best;
      node = 0;
      best = '0;
      for (int i = WIDTH - 1; i >= 0; i--) begin
        alt = kids[node][!key[i]];
        if (alt != 0) begin
          best[i] = 1'b1;
          node = alt;
        end else begin
          node = kids[node][key[i]];
          if (node == 0) break;
        end
      end
      return best;
    endfunction

    function void note_request(cmd_e c, logic [DATA_W-1:0] v);
      trie_result_t r;
      r = '0;
      case (c)
        CMD_INSERT: r.store_full = !insert_key(WIDTH'(v));
        CMD_QUERY: begin
          if (!has_values) r.set_empty = 1'b1;
          else r.max_xor = DATA_W'(max_xor_of(WIDTH'(v)));
        end
        CMD_CLEAR: wipe();
        default: ;
      endcase
      expected_q = {expected_q, r};
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR %0t: %s", $time, msg);
    endtask

    task check_result(logic [DATA_W-1:0] got_xor, logic [1:0] got_flags);
      trie_result_t want;
      seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with no request pending", seen));
        return;
      end
      want = expected_q.pop_front();
      if (got_xor !== want.max_xor)
        report($sformatf("result %0d max_xor %h, expected %h", seen, got_xor, want.max_xor));
      if (got_flags[0] !== want.set_empty)
        report($sformatf("result %0d set_empty %b, expected %b", seen, got_flags[0],
                         want.set_empty));
      if (got_flags[1] !== want.store_full)
        report($sformatf("result %0d store_full %b, expected %b", seen, got_flags[1],
                         want.store_full));
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata;   // value
  logic [1:0]        s_axis_tuser;   // cmd
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;   // max_xor
  logic [1:0]        m_axis_tuser;   // set_empty, store_full

  trie_scoreboard    sb = new();
  logic [DATA_W-1:0] stored_vals[$];
  int                burst_left = 0;
  int                rx_mode = 0;
  int                rx_span = 0;

  binary_trie_max_xor dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: switches between always ready, light stalls, long stalls and toggling
  always @(posedge clk_i) begin
    if (rx_span == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_span = $urandom_range(50, 400);
    end else begin
      rx_span--;
    end
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= ($urandom_range(0, 24) == 0);
      default: m_axis_tready <= ~m_axis_tready;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // one request; valid stays high through a burst and drops for a random gap after it
  task automatic push(cmd_e c, logic [DATA_W-1:0] v);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tuser  <= c;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(c, v);
    if (c == CMD_CLEAR) stored_vals.delete();
    else if (c == CMD_INSERT && stored_vals.size() < 64) stored_vals = {stored_vals, v};
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 6);
    end
  endtask

  // hold off until every pending result has been taken
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    int r;
    int k;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, DATA_W - 1);
    if (r < 55) return $urandom();
    if (r < 70) return $urandom_range(0, 15);
    if (r < 85 && stored_vals.size() != 0)
      return stored_vals[$urandom_range(0, stored_vals.size() - 1)]
             ^ ($urandom_range(0, 1) ? DATA_W'(0) : DATA_W'(1) << k);
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return DATA_W'(1) << k;
      default: return ~(DATA_W'(1) << k);
    endcase
  endfunction

  initial begin
    int n;
    int r;
    cmd_e c;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_INSERT;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty set, unused command, duplicates, extreme keys, clear
    push(CMD_QUERY,  32'h0000_0000);
    push(CMD_QUERY,  32'hFFFF_FFFF);
    push(CMD_NOP,    32'hDEAD_BEEF);
    push(CMD_CLEAR,  32'h0000_0000);
    push(CMD_INSERT, 32'h0000_0000);
    push(CMD_QUERY,  32'hFFFF_FFFF);
    push(CMD_QUERY,  32'h0000_0000);
    push(CMD_INSERT, 32'h0000_0000);
    push(CMD_INSERT, 32'hFFFF_FFFF);
    push(CMD_QUERY,  32'h0000_0000);
    push(CMD_QUERY,  32'h0F0F_0F0F);
    push(CMD_INSERT, 32'h8000_0000);
    push(CMD_QUERY,  32'h7FFF_FFFF);
    push(CMD_INSERT, 32'h1234_5678);
    push(CMD_QUERY,  32'h1234_5678);
    push(CMD_NOP,    32'hFFFF_FFFF);
    push(CMD_CLEAR,  32'h0000_0000);
    push(CMD_QUERY,  32'h1234_5678);
    push(CMD_INSERT, 32'h5555_5555);
    push(CMD_QUERY,  32'hAAAA_AAAA);
    push(CMD_QUERY,  32'h5555_5555);
    push(CMD_INSERT, 32'h0000_0001);
    push(CMD_QUERY,  32'h0000_0001);
    push(CMD_CLEAR,  32'hFFFF_FFFF);
    settle();

    // fill the node store until inserts are turned away, then poke the full trie
    n = 0;
    while (!sb.near_full() && n < 3000) begin
      push(CMD_INSERT, $urandom());
      n++;
    end
    push(CMD_INSERT, $urandom());
    push(CMD_INSERT, stored_vals[0]);
    push(CMD_QUERY,  $urandom());
    push(CMD_QUERY,  32'hFFFF_FFFF);
    push(CMD_NOP,    $urandom());
    push(CMD_INSERT, 32'h0000_0000);
    push(CMD_QUERY,  $urandom());
    settle();
    push(CMD_CLEAR,  $urandom());
    push(CMD_INSERT, $urandom());
    push(CMD_QUERY,  $urandom());

    // random mix, mostly inserts and queries on a growing set
    for (int i = 0; i < 600; i++) begin
      r = $urandom_range(0, 99);
      if (r < 46) c = CMD_INSERT;
      else if (r < 92) c = CMD_QUERY;
      else if (r < 96) c = CMD_CLEAR;
      else c = CMD_NOP;
      push(c, pick_value());
      if ($urandom_range(0, 99) < 3) settle();
    end

    settle();
    repeat (40) @(posedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/btmx_pkg.sv
rtl/btmx_cell.sv
rtl/binary_trie_max_xor.sv
tb/tb_binary_trie_max_xor.sv
